// ----- rtl/pgds_pkg.sv -----
// Shared types and constants of the phase-gated diameter scanner.
package pgds_pkg;

	// Input item operation codes
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_FINISH = 2'd2,
		OP_STOP   = 2'd3
	} pgds_op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PHASE_SPAN   = 3'd0,
		REG_WEIGHT_CH0   = 3'd1,
		REG_WEIGHT_CH1   = 3'd2,
		REG_MIN_DIAMETER = 3'd3,
		REG_LEN_THRESH   = 3'd4
	} pgds_reg_t;

	// Length level codes
	localparam logic [1:0] LVL_SHORT  = 2'd1;
	localparam logic [1:0] LVL_MEDIUM = 2'd2;
	localparam logic [1:0] LVL_LONG   = 2'd3;

	// Field widths
	localparam int SPAN_W   = 12;
	localparam int WEIGHT_W = 16;
	localparam int MIND_W   = 24;
	localparam int THRESH_W = 11;
	localparam int RUN_W    = 11;
	localparam int PASS_W   = 10;
	localparam int TOTAL_W  = 12;
	localparam int DIAM_W   = 19;
	localparam int PROD_W   = RUN_W + WEIGHT_W;
	localparam int NUM_CH   = 4;

	// Saturation limits
	localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
	localparam logic [PASS_W-1:0] PASS_MAX = '1;

	// Register reset values
	localparam logic [SPAN_W-1:0]   SPAN_RST   = 12'd200;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;
	localparam logic [MIND_W-1:0]   MIND_RST   = 24'd256;
	localparam logic [THRESH_W-1:0] THRESH_RST = 11'd5;

	// Per-channel update control
	typedef struct packed {
		logic clr;
		logic upd;
	} pgds_chan_ctl_t;

endpackage

// ----- rtl/pgds_chan.sv -----
// One sensor channel: current high run length and completed pass count.
module pgds_chan
	import pgds_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  pgds_chan_ctl_t      ctl,
	input  logic                beam,
	output logic [RUN_W-1:0]    run_len,
	output logic [PASS_W-1:0]   passes
);

	logic              covered_q;
	logic [RUN_W-1:0]  run_q;
	logic [PASS_W-1:0] pass_q;

	// Clear on start, advance run and pass counters on a taken sample while below the sample limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			covered_q <= 1'b0;
			run_q     <= '0;
			pass_q    <= '0;
		end else if (ctl.clr) begin
			covered_q <= 1'b0;
			run_q     <= '0;
			pass_q    <= '0;
		end else if (ctl.upd) begin
			if (beam) begin
				covered_q <= 1'b1;
				if (!covered_q)
					run_q <= RUN_W'(1);
				else if (run_q != RUN_MAX)
					run_q <= run_q + RUN_W'(1);
			end else if (covered_q) begin
				covered_q <= 1'b0;
				if (pass_q != PASS_MAX)
					pass_q <= pass_q + PASS_W'(1);
			end
		end
	end

	assign run_len = run_q;
	assign passes  = pass_q;

endmodule

// ----- rtl/phase_gated_diameter_scanner_unit.sv -----
// Top level of the phase-gated diameter scanner: registers, item pipeline and result register.
//
// The scanner takes one item per clock cycle when the result side keeps up: an item is
// registered on transfer and updates the scan state from stage 1, and a finish item
// passes three register stages (stage 1, stage 2, result register) from input to
// result.
// Only finish items produce a result; the result register frees the pipeline so that
// items keep flowing while a result waits to be taken. A second finish item waits in
// stage 2 while the first result is not taken, and the input stalls only when a third
// finish item reaches stage 1 while both later stages are held.
// Configuration is written over the APB port and must only change while the scanner idles.
module phase_gated_diameter_scanner_unit
	import pgds_pkg::*;
#(
	parameter int SAMPLE_LIMIT = 1024,
	parameter int PHASE_WIDTH  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Item channel
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [1:0]             operation,
	input  logic [PHASE_WIDTH-1:0] phase,
	input  logic [3:0]             sensors,
	// Result channel
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [DIAM_W-1:0]      diameter,
	output logic [1:0]             length_level,
	output logic [RUN_W-1:0]       run_len_0,
	output logic [RUN_W-1:0]       run_len_1,
	output logic [RUN_W-1:0]       run_len_2,
	output logic [RUN_W-1:0]       run_len_3,
	output logic [PASS_W-1:0]      objects_0,
	output logic [PASS_W-1:0]      objects_1,
	output logic [PASS_W-1:0]      objects_2,
	output logic [PASS_W-1:0]      objects_3,
	output logic [TOTAL_W-1:0]     objects_total
);

	localparam int SCNT_W = $clog2(SAMPLE_LIMIT + 1);
	localparam int CMP_W  = (PHASE_WIDTH > SPAN_W) ? PHASE_WIDTH : SPAN_W;
	localparam logic [SCNT_W-1:0] LIMIT = SCNT_W'(SAMPLE_LIMIT);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SPAN_W-1:0]   phase_span_q;
	logic [WEIGHT_W-1:0] weight_ch0_q;
	logic [WEIGHT_W-1:0] weight_ch1_q;
	logic [MIND_W-1:0]   min_diameter_q;
	logic [THRESH_W-1:0] length_threshold_q;
	logic                cfg_wr;
	pgds_reg_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = pgds_reg_t'(paddr[4:2]);

	// Write a register on the access cycle of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_span_q       <= SPAN_RST;
			weight_ch0_q       <= WEIGHT_RST;
			weight_ch1_q       <= WEIGHT_RST;
			min_diameter_q     <= MIND_RST;
			length_threshold_q <= THRESH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PHASE_SPAN:   phase_span_q       <= pwdata[SPAN_W-1:0];
				REG_WEIGHT_CH0:   weight_ch0_q       <= pwdata[WEIGHT_W-1:0];
				REG_WEIGHT_CH1:   weight_ch1_q       <= pwdata[WEIGHT_W-1:0];
				REG_MIN_DIAMETER: min_diameter_q     <= pwdata[MIND_W-1:0];
				REG_LEN_THRESH:   length_threshold_q <= pwdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (cfg_idx)
			REG_PHASE_SPAN:   prdata = 32'(phase_span_q);
			REG_WEIGHT_CH0:   prdata = 32'(weight_ch0_q);
			REG_WEIGHT_CH1:   prdata = 32'(weight_ch1_q);
			REG_MIN_DIAMETER: prdata = 32'(min_diameter_q);
			REG_LEN_THRESH:   prdata = 32'(length_threshold_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	logic v_s1, v_s2, res_valid_q;
	logic s1_adv, s1_free, s2_adv, s2_free;
	pgds_op_t               op_s1;
	logic [PHASE_WIDTH-1:0] phase_s1;
	logic [3:0]             sensors_s1;

	assign s2_adv     = v_s2 && (!res_valid_q || result_ready);
	assign s2_free    = !v_s2 || s2_adv;
	assign s1_adv     = v_s1 && ((op_s1 != OP_FINISH) || s2_free);
	assign s1_free    = !v_s1 || s1_adv;
	assign item_ready = s1_free;

	// Hold stage valids; a stage reloads when it empties or moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				v_s1 <= item_valid;
			if (s2_free)
				v_s2 <= s1_adv && (op_s1 == OP_FINISH);
			if (s2_adv)
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;
		end
	end

	// Capture the input item on transfer
	always_ff @(posedge clk) begin
		if (item_valid && s1_free) begin
			op_s1      <= pgds_op_t'(operation);
			phase_s1   <= phase;
			sensors_s1 <= sensors;
		end
	end

	// ------------------------------------------------------------------
	// Scan state update (stage 1)
	// ------------------------------------------------------------------
	logic                   armed_q;
	logic                   phase_seen_q;
	logic [PHASE_WIDTH-1:0] prev_phase_q;
	logic [SCNT_W-1:0]      samples_q;
	logic                   fwd;
	logic                   take;
	logic                   room;
	logic [PHASE_WIDTH-1:0] back_dist;
	pgds_chan_ctl_t         chan_ctl;
	logic [RUN_W-1:0]       run_len  [NUM_CH];
	logic [PASS_W-1:0]      pass_cnt [NUM_CH];

	// Decide whether the phase moves forward, wraps included
	always_comb begin
		back_dist = prev_phase_q - phase_s1;
		if (!phase_seen_q)
			fwd = 1'b1;
		else if (phase_s1 > prev_phase_q)
			fwd = 1'b1;
		else
			fwd = CMP_W'(back_dist) > CMP_W'(phase_span_q >> 1);
	end

	assign take         = s1_adv && (op_s1 == OP_SAMPLE) && armed_q && fwd;
	assign room         = samples_q < LIMIT;
	assign chan_ctl.clr = s1_adv && (op_s1 == OP_START);
	assign chan_ctl.upd = take && room;

	// Arm, disarm and track phase and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			phase_seen_q <= 1'b0;
			prev_phase_q <= '0;
			samples_q    <= '0;
		end else if (s1_adv) begin
			unique case (op_s1)
				OP_START: begin
					armed_q      <= 1'b1;
					phase_seen_q <= 1'b0;
					prev_phase_q <= '0;
					samples_q    <= '0;
				end
				OP_SAMPLE: begin
					if (take) begin
						phase_seen_q <= 1'b1;
						prev_phase_q <= phase_s1;
						if (room)
							samples_q <= samples_q + SCNT_W'(1);
					end
				end
				OP_FINISH, OP_STOP: begin
					armed_q <= 1'b0;
				end
			endcase
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		pgds_chan u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (chan_ctl),
			.beam    (sensors_s1[c]),
			.run_len (run_len[c]),
			.passes  (pass_cnt[c])
		);
	end

	// ------------------------------------------------------------------
	// Weighting and level (stage 1 to stage 2)
	// ------------------------------------------------------------------
	logic [1:0]        level;
	logic [PROD_W-1:0] p0_s2, p1_s2;
	logic [1:0]        level_s2;
	logic [RUN_W-1:0]  run_s2  [NUM_CH];
	logic [PASS_W-1:0] pass_s2 [NUM_CH];

	// Grade the length level from channels 3 and 2 against the length threshold, channel 3 first
	always_comb begin
		priority if (run_len[3] >= length_threshold_q)
			level = LVL_LONG;
		else if (run_len[2] >= length_threshold_q)
			level = LVL_MEDIUM;
		else
			level = LVL_SHORT;
	end

	// Latch the finish snapshot and weighted run lengths
	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && (op_s1 == OP_FINISH)) begin
			p0_s2    <= PROD_W'(run_len[0]) * PROD_W'(weight_ch0_q);
			p1_s2    <= PROD_W'(run_len[1]) * PROD_W'(weight_ch1_q);
			level_s2 <= level;
			run_s2   <= run_len;
			pass_s2  <= pass_cnt;
		end
	end

	// ------------------------------------------------------------------
	// Diameter and totals (stage 2 to result register)
	// ------------------------------------------------------------------
	logic                  keep0, keep1;
	logic [PROD_W:0]       sum_both, sum0, sum1;
	logic [DIAM_W-1:0]     diam;
	logic [TOTAL_W-1:0]    total;

	assign keep0    = p0_s2 >= PROD_W'(min_diameter_q);
	assign keep1    = p1_s2 >= PROD_W'(min_diameter_q);
	assign sum_both = (PROD_W+1)'(p0_s2) + (PROD_W+1)'(p1_s2) + (PROD_W+1)'(256);
	assign sum0     = (PROD_W+1)'(p0_s2) + (PROD_W+1)'(128);
	assign sum1     = (PROD_W+1)'(p1_s2) + (PROD_W+1)'(128);

	// Round one kept product, or the average of both; zero when neither is kept
	always_comb begin
		priority if (keep0 && keep1)
			diam = sum_both[DIAM_W+8:9];
		else if (keep0)
			diam = sum0[DIAM_W+7:8];
		else if (keep1)
			diam = sum1[DIAM_W+7:8];
		else
			diam = '0;
	end

	assign total = TOTAL_W'(pass_s2[0]) + TOTAL_W'(pass_s2[1])
		+ TOTAL_W'(pass_s2[2]) + TOTAL_W'(pass_s2[3]);

	logic [DIAM_W-1:0]  diameter_q;
	logic [1:0]         level_q;
	logic [RUN_W-1:0]   run_q   [NUM_CH];
	logic [PASS_W-1:0]  pass_q  [NUM_CH];
	logic [TOTAL_W-1:0] total_q;

	// Load the result register when stage 2 moves on
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			diameter_q <= diam;
			level_q    <= level_s2;
			run_q      <= run_s2;
			pass_q     <= pass_s2;
			total_q    <= total;
		end
	end

	assign result_valid  = res_valid_q;
	assign diameter      = diameter_q;
	assign length_level  = level_q;
	assign run_len_0     = run_q[0];
	assign run_len_1     = run_q[1];
	assign run_len_2     = run_q[2];
	assign run_len_3     = run_q[3];
	assign objects_0     = pass_q[0];
	assign objects_1     = pass_q[1];
	assign objects_2     = pass_q[2];
	assign objects_3     = pass_q[3];
	assign objects_total = total_q;

endmodule
